// ----- rtl/bqdd_pkg.sv -----
// shared types, codes and constants of the blue queue drop decider
`default_nettype none

package bqdd_pkg;

  // time and level constants
  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam int unsigned RAISE_SHIFT  = 3;

  // register reset values
  localparam logic [15:0] QLIMIT_RST   = 16'd200;
  localparam logic [15:0] MAXLEVEL_RST = 16'd1000;
  localparam logic [31:0] HOLD_RST     = 32'd50000;

  // remainder unit: two quotient bits per cycle over a 32-bit padded dividend
  localparam int unsigned RND_W      = 31;
  localparam int unsigned DIV_BITS   = 32;
  localparam int unsigned DIV_STEPS  = DIV_BITS / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // request codes
  typedef enum logic [1:0] {
    FUNC_ARRIVE  = 2'd0,
    FUNC_DEQUEUE = 2'd1,
    FUNC_PURGE   = 2'd2
  } func_e;

  // result codes
  typedef enum logic [2:0] {
    ACT_QUEUED   = 3'd0,
    ACT_MARKED   = 3'd1,
    ACT_EARLY    = 3'd2,
    ACT_FORCED   = 3'd3,
    ACT_DEQUEUED = 3'd4,
    ACT_EMPTY    = 3'd5,
    ACT_PURGED   = 3'd6
  } act_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_QLIMIT   = 2'd0,
    REG_MAXLEVEL = 2'd1,
    REG_HOLD     = 2'd2,
    REG_ECN      = 2'd3
  } reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DEC
  } state_e;

  // input request
  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      now_sec;
    logic [19:0]      now_usec;
    logic [RND_W-1:0] random_value;
    logic             ecn_markable;
  } in_t;

  // result
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] mark_level;
    logic [15:0] queue_length;
    logic [31:0] sent_packets;
    logic [31:0] dropped_packets;
    logic [31:0] forced_drops;
    logic [31:0] early_drops;
    logic [31:0] mark_total;
  } out_t;

  // remainder unit status
  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } rem_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bqdd_rem.sv -----
// iterative remainder unit, two restoring steps per cycle
`default_nettype none

module bqdd_rem
  import bqdd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RND_W-1:0] dividend_i,
  input  wire logic [15:0]      divisor_i,
  output rem_stat_t             stat_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_BITS-1:0]  shf_q, shf_d;
  logic [15:0]          rem_q, rem_d;
  logic [16:0]          r1, r2;
  logic [15:0]          r1s;

  // one pair of restoring steps
  always_comb begin
    r1 = {rem_q, shf_q[DIV_BITS-1]};
    if (r1 >= {1'b0, divisor_i}) begin
      r1 = r1 - {1'b0, divisor_i};
    end
    r1s = r1[15:0];
    r2 = {r1s, shf_q[DIV_BITS-2]};
    if (r2 >= {1'b0, divisor_i}) begin
      r2 = r2 - {1'b0, divisor_i};
    end
  end

  // sequencing of the steps
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      shf_d = {1'b0, dividend_i};
      rem_d = '0;
    end else if (run_q) begin
      rem_d = r2[15:0];
      shf_d = {shf_q[DIV_BITS-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/blue_queue_drop_decider_unit.sv -----
// blue queue drop decider: top level with sequencer, state and register port
//
//  channel | signals                       | moves
//  --------+-------------------------------+-----------------------------
//  in      | in_valid_i/in_ready_o         | one request (bqdd_pkg::in_t)
//  out     | out_valid_o/out_ready_i       | one result (bqdd_pkg::out_t)
//  cfg     | psel/penable/pwrite/paddr ... | register writes and reads
//
// an arrival passes S_MUL for the seconds scaling, then S_DIV (16 two-bit remainder steps
// and the done flag), then S_DEC to commit, and goes back to idle
// dequeue and purge requests go from idle straight to S_DEC; in_ready_o is high only when idle
// the result register frees the input side; a request waits before commit
// while an earlier result is still held
// reset is asynchronous, active low, and clears state and registers at once
`default_nettype none

module blue_queue_drop_decider_unit
  import bqdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire in_t         in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      out_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam logic signed [20:0] USEC_C = 21'(USEC_PER_SEC);

  // configuration registers
  logic [15:0] qlimit_q;
  logic [15:0] maxlvl_q;
  logic [31:0] hold_q;
  logic        ecn_q;
  logic        cfg_wr;
  reg_e        cfg_idx;

  // block state
  logic [15:0] level_q, level_d;
  logic        idle_q, idle_d;
  logic [31:0] lsec_q, lsec_d;
  logic [19:0] lusec_q, lusec_d;
  logic [15:0] held_q, held_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] drop_q, drop_d;
  logic [31:0] forced_q, forced_d;
  logic [31:0] early_q, early_d;
  logic [31:0] mark_q, mark_d;

  // sequencer and datapath
  state_e             state_q, state_d;
  in_t                item_q;
  logic signed [32:0] ds_q;
  logic signed [53:0] prod_q;
  logic               div_start;
  rem_stat_t          rem_stat;
  logic               commit;
  logic               has_result;
  out_t               out_q;
  logic               out_valid_q;
  logic               in_acc;

  logic signed [20:0] du;
  logic signed [53:0] elapsed;
  logic               gt_hold;
  logic               ds_gt1;
  logic [15:0]        lvl;
  logic               early_hit, do_mark, do_early, do_forced;
  logic [16:0]        raised;
  act_e               act;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_QLIMIT:   prdata = {16'd0, qlimit_q};
      REG_MAXLEVEL: prdata = {16'd0, maxlvl_q};
      REG_HOLD:     prdata = hold_q;
      REG_ECN:      prdata = {31'd0, ecn_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlimit_q <= QLIMIT_RST;
      maxlvl_q <= MAXLEVEL_RST;
      hold_q   <= HOLD_RST;
      ecn_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_QLIMIT:   qlimit_q <= pwdata[15:0];
        REG_MAXLEVEL: maxlvl_q <= pwdata[15:0];
        REG_HOLD:     hold_q   <= pwdata;
        REG_ECN:      ecn_q    <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // remainder unit for the random draw
  bqdd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_q.random_value),
    .divisor_i  (maxlvl_q),
    .stat_o     (rem_stat)
  );

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.func == FUNC_ARRIVE) ? S_MUL : S_DEC;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (rem_stat.done) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture, seconds difference and its scaling to microseconds
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
      ds_q   <= $signed({1'b0, in_data_i.now_sec}) - $signed({1'b0, lsec_q});
    end
    if (state_q == S_MUL) begin
      prod_q <= ds_q * USEC_C;
    end
  end

  // elapsed time against the hold time
  assign du      = $signed({1'b0, item_q.now_usec}) - $signed({1'b0, lusec_q});
  assign elapsed = prod_q + 54'(du);
  assign gt_hold = elapsed > $signed({22'd0, hold_q});
  assign ds_gt1  = ds_q > 33'sd1;

  // decision and state update
  always_comb begin
    level_d    = level_q;
    idle_d     = idle_q;
    lsec_d     = lsec_q;
    lusec_d    = lusec_q;
    held_d     = held_q;
    sent_d     = sent_q;
    drop_d     = drop_q;
    forced_d   = forced_q;
    early_d    = early_q;
    mark_d     = mark_q;
    act        = ACT_QUEUED;
    has_result = 1'b1;
    lvl        = level_q;
    early_hit  = 1'b0;
    do_mark    = 1'b0;
    do_early   = 1'b0;
    do_forced  = 1'b0;
    raised     = '0;
    case (item_q.func)
      FUNC_ARRIVE: begin
        // level decay after an idle period
        if (idle_q) begin
          idle_d = 1'b0;
          if (ds_gt1) begin
            lvl     = 16'd1;
            lsec_d  = item_q.now_sec;
            lusec_d = item_q.now_usec;
          end else if (gt_hold) begin
            if (lvl != 16'd0) begin
              lvl = lvl - 16'd1;
            end
            lsec_d  = item_q.now_sec;
            lusec_d = item_q.now_usec;
          end
        end
        // early mark or drop
        early_hit = (maxlvl_q != 16'd0) && (rem_stat.rem < lvl) && (held_q > 16'd1);
        do_mark   = early_hit && ecn_q && item_q.ecn_markable;
        do_early  = early_hit && !do_mark;
        do_forced = !do_early && (held_q >= qlimit_q);
        if (do_mark) begin
          mark_d = mark_q + 32'd1;
          act    = ACT_MARKED;
        end
        if (do_early) begin
          early_d = early_q + 32'd1;
          drop_d  = drop_q + 32'd1;
          act     = ACT_EARLY;
        end else if (do_forced) begin
          // level rise, at most once per hold time
          if (gt_hold && !idle_q) begin
            raised = {1'b0, lvl} + 17'(maxlvl_q >> RAISE_SHIFT);
            if (raised > {1'b0, maxlvl_q}) begin
              raised = {1'b0, maxlvl_q};
            end
            lvl     = raised[15:0];
            lsec_d  = item_q.now_sec;
            lusec_d = item_q.now_usec;
          end
          forced_d = forced_q + 32'd1;
          drop_d   = drop_q + 32'd1;
          act      = ACT_FORCED;
        end else begin
          held_d = held_q + 16'd1;
        end
        level_d = lvl;
      end
      FUNC_DEQUEUE: begin
        if (held_q == 16'd0) begin
          if (!idle_q) begin
            idle_d  = 1'b1;
            lsec_d  = item_q.now_sec;
            lusec_d = item_q.now_usec;
          end
          act = ACT_EMPTY;
        end else begin
          held_d = held_q - 16'd1;
          idle_d = 1'b0;
          sent_d = sent_q + 32'd1;
          act    = ACT_DEQUEUED;
        end
      end
      FUNC_PURGE: begin
        held_d = '0;
        act    = ACT_PURGED;
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      idle_q   <= 1'b1;
      lsec_q   <= '0;
      lusec_q  <= '0;
      held_q   <= '0;
      sent_q   <= '0;
      drop_q   <= '0;
      forced_q <= '0;
      early_q  <= '0;
      mark_q   <= '0;
    end else if (commit) begin
      level_q  <= level_d;
      idle_q   <= idle_d;
      lsec_q   <= lsec_d;
      lusec_q  <= lusec_d;
      held_q   <= held_d;
      sent_q   <= sent_d;
      drop_q   <= drop_d;
      forced_q <= forced_d;
      early_q  <= early_d;
      mark_q   <= mark_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && has_result) begin
      out_q.action          <= act;
      out_q.mark_level      <= level_d;
      out_q.queue_length    <= held_d;
      out_q.sent_packets    <= sent_d;
      out_q.dropped_packets <= drop_d;
      out_q.forced_drops    <= forced_d;
      out_q.early_drops     <= early_d;
      out_q.mark_total      <= mark_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// testbench for the blue queue drop decider: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb;
  import bqdd_pkg::*;

  // selector with no meaning: the block takes it and answers nothing
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  blue_queue_drop_decider_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // predicted register copies
  logic [15:0] limit_cfg  = QLIMIT_RST;
  logic [15:0] maxlvl_cfg = MAXLEVEL_RST;
  logic [31:0] hold_cfg   = HOLD_RST;
  logic        ecn_cfg    = 1'b0;

  // predicted queue state
  logic [15:0] level_q    = '0;
  logic        idle_q     = 1'b1;
  logic [31:0] stamp_sec  = '0;
  logic [19:0] stamp_usec = '0;
  logic [15:0] held_q     = '0;
  logic [31:0] sent_q     = '0;
  logic [31:0] drop_q     = '0;
  logic [31:0] forced_q   = '0;
  logic [31:0] early_q    = '0;
  logic [31:0] mark_q     = '0;

  out_t        verdicts_due[$];
  int unsigned mismatches = 0;
  bit          steady     = 1'b0;

  // time cursor for random requests
  logic [31:0] now_s  = '0;
  int unsigned now_us = 0;

  // signed microseconds since the last level update
  function automatic longint usec_since_stamp(logic [31:0] s, logic [19:0] u);
    longint ds, du;
    ds = $signed({32'b0, s}) - $signed({32'b0, stamp_sec});
    du = $signed({44'b0, u}) - $signed({44'b0, stamp_usec});
    return ds * 1000000 + du;
  endfunction

  // blue decision for one request; returns 0 where no verdict is given
  function automatic bit blue_verdict(input in_t req, output out_t res);
    logic [16:0] raised;
    longint      gap_sec;
    act_e        act;
    bit          early;
    bit          forced;
    early  = 1'b0;
    forced = 1'b0;
    act    = ACT_QUEUED;
    res    = '0;
    case (req.func)
      FUNC_ARRIVE: begin
        // first arrival after idling relaxes the level
        if (idle_q) begin
          gap_sec = $signed({32'b0, req.now_sec}) - $signed({32'b0, stamp_sec});
          idle_q  = 1'b0;
          if (gap_sec > 1) begin
            level_q    = 16'd1;
            stamp_sec  = req.now_sec;
            stamp_usec = req.now_usec;
          end else if (usec_since_stamp(req.now_sec, req.now_usec) >
                       $signed({32'b0, hold_cfg})) begin
            if (level_q != 0) level_q = level_q - 16'd1;
            stamp_sec  = req.now_sec;
            stamp_usec = req.now_usec;
          end
        end
        // early mark or drop
        if (maxlvl_cfg != 0 && held_q > 16'd1 &&
            (req.random_value % {15'b0, maxlvl_cfg}) < {15'b0, level_q}) begin
          if (ecn_cfg && req.ecn_markable) begin
            mark_q = mark_q + 32'd1;
            act    = ACT_MARKED;
          end else begin
            early = 1'b1;
          end
        end
        if (!early && held_q >= limit_cfg) forced = 1'b1;
        if (early) begin
          early_q = early_q + 32'd1;
          drop_q  = drop_q + 32'd1;
          act     = ACT_EARLY;
        end else if (forced) begin
          // full queue pushes the level up, once per hold time
          if (usec_since_stamp(req.now_sec, req.now_usec) > $signed({32'b0, hold_cfg})) begin
            raised = {1'b0, level_q} + {4'b0, maxlvl_cfg[15:RAISE_SHIFT]};
            if (raised > {1'b0, maxlvl_cfg}) raised = {1'b0, maxlvl_cfg};
            level_q    = raised[15:0];
            stamp_sec  = req.now_sec;
            stamp_usec = req.now_usec;
          end
          forced_q = forced_q + 32'd1;
          drop_q   = drop_q + 32'd1;
          act      = ACT_FORCED;
        end else begin
          held_q = held_q + 16'd1;
        end
      end
      FUNC_DEQUEUE: begin
        if (held_q == 0) begin
          if (!idle_q) begin
            idle_q     = 1'b1;
            stamp_sec  = req.now_sec;
            stamp_usec = req.now_usec;
          end
          act = ACT_EMPTY;
        end else begin
          held_q = held_q - 16'd1;
          idle_q = 1'b0;
          sent_q = sent_q + 32'd1;
          act    = ACT_DEQUEUED;
        end
      end
      FUNC_PURGE: begin
        held_q = '0;
        act    = ACT_PURGED;
      end
      default: return 1'b0;
    endcase
    res.action          = act;
    res.mark_level      = level_q;
    res.queue_length    = held_q;
    res.sent_packets    = sent_q;
    res.dropped_packets = drop_q;
    res.forced_drops    = forced_q;
    res.early_drops     = early_q;
    res.mark_total      = mark_q;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  // result check: sampled mid-cycle, accepted at the next rising edge
  always @(negedge clk_i) begin : verdict_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch("result with nothing due");
      end else begin
        want = verdicts_due.pop_front();
        compare_field("action", 32'(out_data_o.action), 32'(want.action));
        compare_field("mark_level", 32'(out_data_o.mark_level), 32'(want.mark_level));
        compare_field("queue_length", 32'(out_data_o.queue_length), 32'(want.queue_length));
        compare_field("sent_packets", out_data_o.sent_packets, want.sent_packets);
        compare_field("dropped_packets", out_data_o.dropped_packets, want.dropped_packets);
        compare_field("forced_drops", out_data_o.forced_drops, want.forced_drops);
        compare_field("early_drops", out_data_o.early_drops, want.early_drops);
        compare_field("mark_total", out_data_o.mark_total, want.mark_total);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 31);

  // one request through the handshake, prediction at acceptance
  task automatic offer_request(input in_t req);
    out_t res;
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    if (blue_verdict(req, res)) verdicts_due.push_back(res);
  endtask

  task automatic post(input logic [1:0] op, input logic [31:0] s, input logic [19:0] u,
                      input logic [30:0] rnd, input logic mk);
    in_t req;
    req.func         = op;
    req.now_sec      = s;
    req.now_usec     = u;
    req.random_value = rnd;
    req.ecn_markable = mk;
    offer_request(req);
  endtask

  // hold off until every verdict is in, then let a silent request finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_QLIMIT:   limit_cfg  = val[15:0];
      REG_MAXLEVEL: maxlvl_cfg = val[15:0];
      REG_HOLD:     hold_cfg   = val;
      REG_ECN:      ecn_cfg    = val[0];
      default: ;
    endcase
  endtask

  task automatic set_policy(input logic [15:0] lim, input logic [15:0] maxlvl,
                            input logic [31:0] hold, input logic ecn);
    write_reg(REG_QLIMIT, {16'b0, lim});
    write_reg(REG_MAXLEVEL, {16'b0, maxlvl});
    write_reg(REG_HOLD, hold);
    write_reg(REG_ECN, {31'b0, ecn});
  endtask

  // moves the time cursor: mostly forward, sometimes seconds, back, or odd micros
  task automatic next_time(output logic [31:0] s, output logic [19:0] u);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) now_us += $urandom_range(3000);
    else if (r < 85) now_us += $urandom_range(150000);
    else if (r < 93) now_s += $urandom_range(3, 1);
    else if (r < 97) begin
      now_s  = now_s - 32'd1;
      now_us = $urandom_range(999999);
    end
    if (now_us >= 1000000) begin
      now_s  = now_s + 32'd1;
      now_us = now_us - 1000000;
    end
    s = now_s;
    u = now_us[19:0];
    if (r >= 97) u = 20'($urandom_range(1048575, 1000000));
  endtask

  // bursts that fill the queue and bursts that drain it, chosen at random
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    bit          fill;
    logic [1:0]  op;
    logic [31:0] s;
    logic [19:0] u;
    logic [30:0] rnd;
    sent  = 0;
    burst = 0;
    fill  = 1'b1;
    while (sent < count) begin
      if (burst == 0) begin
        fill  = ($urandom_range(99) < 60);
        burst = $urandom_range(12, 3);
      end
      burst--;
      r = $urandom_range(99);
      if (r < 2) op = FUNC_NONE;
      else if (r < 5) op = FUNC_PURGE;
      else if (fill ? (r < 80) : (r < 30)) op = FUNC_ARRIVE;
      else op = FUNC_DEQUEUE;
      r = $urandom_range(9);
      rnd = (r == 0) ? 31'd0 : (r == 1) ? 31'h7FFF_FFFF : 31'($urandom);
      next_time(s, u);
      post(op, s, u, rnd, 1'($urandom));
      if (op != FUNC_NONE) sent++;
    end
  endtask

  // reset register values: empty dequeue, arrivals, idling, odd times, purge
  task automatic test_reset_policy();
    post(FUNC_DEQUEUE, 32'd0, 20'd0, 31'd0, 1'b0);
    post(FUNC_ARRIVE, 32'd0, 20'd0, 31'd0, 1'b0);
    post(FUNC_ARRIVE, 32'd0, 20'd10, 31'h7FFF_FFFF, 1'b1);
    post(FUNC_ARRIVE, 32'd0, 20'd20, 31'd0, 1'b1);
    post(FUNC_DEQUEUE, 32'd0, 20'd30, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd0, 20'd40, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd0, 20'd50, 31'd0, 1'b0);
    // dequeue on empty while busy: goes idle and stamps
    post(FUNC_DEQUEUE, 32'd1, 20'd0, 31'd0, 1'b0);
    post(FUNC_ARRIVE, 32'd1, 20'd100000, 31'd5, 1'b0);
    post(FUNC_DEQUEUE, 32'd1, 20'd200000, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd5, 20'd0, 31'd0, 1'b0);
    // several seconds idle resets the level to one
    post(FUNC_ARRIVE, 32'd9, 20'd0, 31'd0, 1'b0);
    post(FUNC_ARRIVE, 32'd9, 20'hFFFFF, 31'd1, 1'b1);
    post(FUNC_ARRIVE, 32'd3, 20'd0, 31'd2, 1'b0);
    post(FUNC_NONE, 32'd3, 20'd1, 31'd0, 1'b0);
    post(FUNC_PURGE, 32'd3, 20'd2, 31'd0, 1'b0);
    post(FUNC_ARRIVE, 32'hFFFF_FFFF, 20'd999999, 31'd0, 1'b1);
    settle();
  endtask

  // zero limit and zero modulus, level clamp, mark then full, early drop
  task automatic test_edge_policy();
    set_policy(16'd0, 16'd0, 32'd0, 1'b1);
    post(FUNC_ARRIVE, 32'd100, 20'd0, 31'd0, 1'b1);
    post(FUNC_ARRIVE, 32'd100, 20'd5, 31'd0, 1'b0);
    settle();
    set_policy(16'd2, 16'd800, 32'd0, 1'b1);
    post(FUNC_ARRIVE, 32'd101, 20'd0, 31'd799, 1'b0);
    post(FUNC_ARRIVE, 32'd101, 20'd10, 31'd799, 1'b0);
    post(FUNC_ARRIVE, 32'd101, 20'd20, 31'd799, 1'b0);
    post(FUNC_ARRIVE, 32'd101, 20'd30, 31'd799, 1'b0);
    settle();
    write_reg(REG_MAXLEVEL, 32'd16);
    post(FUNC_ARRIVE, 32'd102, 20'd0, 31'd5, 1'b1);
    settle();
    write_reg(REG_QLIMIT, 32'd3);
    post(FUNC_ARRIVE, 32'd102, 20'd10, 31'd5, 1'b1);
    post(FUNC_ARRIVE, 32'd102, 20'd20, 31'd5, 1'b0);
    post(FUNC_DEQUEUE, 32'd102, 20'd30, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd102, 20'd40, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd102, 20'd50, 31'd0, 1'b0);
    post(FUNC_DEQUEUE, 32'd102, 20'd60, 31'd0, 1'b0);
    settle();
  endtask

  task automatic test_random_small_queue();
    set_policy(16'd6, 16'd16, 32'd2000, 1'b1);
    now_s  = $urandom;
    now_us = $urandom_range(999999);
    run_random(120);
    settle();
  endtask

  task automatic test_random_extremes();
    set_policy(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    run_random(50);
    settle();
  endtask

  task automatic test_random_tight();
    set_policy(16'd1, 16'd1, 32'd0, 1'b1);
    run_random(50);
    settle();
  endtask

  // no idling on either side; the sender holds back midway
  task automatic test_random_steady();
    set_policy(16'($urandom_range(12, 2)), 16'($urandom_range(200, 8)),
               32'($urandom_range(10000)), 1'($urandom));
    steady = 1'b1;
    run_random(50);
    settle();
    run_random(50);
    settle();
    steady = 1'b0;
  endtask

  task automatic test_random_sweep();
    int k;
    for (k = 0; k < 3; k++) begin
      set_policy(16'($urandom_range(40, 2)), 16'($urandom_range(4000, 2)),
                 32'($urandom_range(60000)), 1'($urandom));
      run_random(30);
      settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_policy();
    test_edge_policy();
    test_random_small_queue();
    test_random_extremes();
    test_random_tight();
    test_random_steady();
    test_random_sweep();
    settle();
    if (mismatches == 0 && verdicts_due.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule
